// ===== src/sha256_pkg.sv =====
// shared types, constants and round tables of the sha-256 engine
package sha256_pkg;

	localparam int ROUNDS = 64;
	localparam int WORDS = 16;
	localparam int HASH_WORDS = 8;

	localparam logic [31:0] K_TABLE [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] IV_TABLE [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// last run count: the counter covers every round, plus a leading phase that fetches the first word
	localparam logic [7:0] RUN_LAST = 8'(2 * ROUNDS + 1);

	localparam logic [7:0] PAD_MARK = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_INIT,
		ST_RUN,
		ST_ADD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        run;
		logic [7:0]  cnt;
		logic        load;
		logic        add;
		logic        iv;
		logic        wr_en;
		logic [3:0]  wr_addr;
		logic [31:0] wr_data;
	} ctl_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== src/sha256_hash.sv =====
// top level of the sha-256 engine: byte intake, padding and sequencing
// The engine takes a message one byte per request and, on the request that
// ends the message, returns the eight 32-bit digest words in order. A byte
// request is taken while the engine is idle; each full 64-byte block then
// holds the input through a load step, the compression rounds, each reading
// the 16-word schedule memory through its two read ports, and a fold of the
// result into the chain. The end of a message adds up to 16 padding words
// per padding block, one or two block compressions, and eight output words;
// the next message is taken once the last digest word has been delivered.
module sha256_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte[7:0]
	input  logic        s_tuser,   // has_byte
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
	output logic        m_tlast    // last_word
);

	sha256_pkg::state_t state_q, state_nxt, after_q;
	sha256_pkg::ctl_t   ctl;

	logic [5:0]  fill_q, fill_inc, fill_new;
	logic [31:0] word_q, word_in, mark_word, pad_word;
	logic [63:0] bitlen_q;
	logic [3:0]  pad_idx_q;
	logic        first_q, final_q;
	logic [7:0]  cnt_q;
	logic [2:0]  oidx_q;
	logic        acc, has, out_done;
	logic [31:0] w, digest;

	assign acc = s_tvalid && s_tready;
	assign has = s_tuser;
	assign fill_inc = fill_q + 6'd1;
	assign fill_new = has ? fill_inc : fill_q;
	assign out_done = (state_q == sha256_pkg::ST_OUT) && m_tready && (oidx_q == 3'd7);

	always_comb begin
		word_in = word_q;
		mark_word = 32'd0;
		for (int j = 0; j < 4; j++) begin
			if (2'(j) == fill_q[1:0]) begin
				word_in[31 - 8 * j -: 8] = s_tdata[7:0];
				mark_word[31 - 8 * j -: 8] = sha256_pkg::PAD_MARK;
			end else if (2'(j) < fill_q[1:0]) begin
				mark_word[31 - 8 * j -: 8] = word_q[31 - 8 * j -: 8];
			end
		end
	end

	always_comb begin
		if (first_q) begin
			pad_word = mark_word;
		end else if (final_q && pad_idx_q == 4'd14) begin
			pad_word = bitlen_q[63:32];
		end else if (final_q && pad_idx_q == 4'd15) begin
			pad_word = bitlen_q[31:0];
		end else begin
			pad_word = 32'd0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (acc) begin
					if (has && fill_q == 6'd63) begin
						state_nxt = sha256_pkg::ST_INIT;
					end else if (s_tlast) begin
						state_nxt = sha256_pkg::ST_PAD;
					end
				end
			end
			sha256_pkg::ST_PAD: begin
				if (pad_idx_q == 4'd15) begin
					state_nxt = sha256_pkg::ST_INIT;
				end
			end
			sha256_pkg::ST_INIT: state_nxt = sha256_pkg::ST_RUN;
			sha256_pkg::ST_RUN: begin
				if (cnt_q == sha256_pkg::RUN_LAST) begin
					state_nxt = sha256_pkg::ST_ADD;
				end
			end
			sha256_pkg::ST_ADD: state_nxt = after_q;
			sha256_pkg::ST_OUT: begin
				if (out_done) begin
					state_nxt = sha256_pkg::ST_IDLE;
				end
			end
			default: state_nxt = sha256_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		ctl = '0;
		ctl.cnt = cnt_q;
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				ctl.wr_en = acc && has && (fill_q[1:0] == 2'd3);
				ctl.wr_addr = fill_q[5:2];
				ctl.wr_data = word_in;
			end
			sha256_pkg::ST_PAD: begin
				ctl.wr_en = 1'b1;
				ctl.wr_addr = pad_idx_q;
				ctl.wr_data = pad_word;
			end
			sha256_pkg::ST_INIT: ctl.load = 1'b1;
			sha256_pkg::ST_RUN: ctl.run = 1'b1;
			sha256_pkg::ST_ADD: ctl.add = 1'b1;
			sha256_pkg::ST_OUT: begin
				m_tvalid = 1'b1;
				ctl.iv = out_done;
			end
			default: ctl = '0;
		endcase
	end

	assign m_tdata = {5'd0, oidx_q, digest};
	assign m_tlast = (oidx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::ST_IDLE;
			after_q <= sha256_pkg::ST_IDLE;
			fill_q <= 6'd0;
			bitlen_q <= 64'd0;
			pad_idx_q <= 4'd0;
			first_q <= 1'b0;
			final_q <= 1'b0;
			cnt_q <= 8'd0;
			oidx_q <= 3'd0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				sha256_pkg::ST_IDLE: begin
					if (acc) begin
						if (has) begin
							fill_q <= fill_inc;
							bitlen_q <= bitlen_q + 64'd8;
						end
						pad_idx_q <= fill_new[5:2];
						first_q <= 1'b1;
						if (has && fill_q == 6'd63) begin
							final_q <= 1'b1;
							after_q <= s_tlast ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
						end else begin
							final_q <= (fill_new[5:3] != 3'b111);
						end
					end
				end
				sha256_pkg::ST_PAD: begin
					pad_idx_q <= pad_idx_q + 4'd1;
					first_q <= 1'b0;
					if (pad_idx_q == 4'd15) begin
						after_q <= final_q ? sha256_pkg::ST_OUT : sha256_pkg::ST_PAD;
						final_q <= 1'b1;
					end
				end
				sha256_pkg::ST_INIT: cnt_q <= 8'd0;
				sha256_pkg::ST_RUN: cnt_q <= cnt_q + 8'd1;
				sha256_pkg::ST_OUT: begin
					if (m_tready) begin
						oidx_q <= oidx_q + 3'd1;
					end
					if (out_done) begin
						fill_q <= 6'd0;
						bitlen_q <= 64'd0;
					end
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && has) begin
			word_q <= word_in;
		end
	end

	sha256_sched u_sched (
		.clk    (clk),
		.ctl    (ctl),
		.w      (w)
	);

	sha256_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.w      (w),
		.sel    (oidx_q),
		.digest (digest)
	);

endmodule

// ===== src/sha256_sched.sv =====
// message word memory and message schedule expansion
module sha256_sched (
	input  logic               clk,
	input  sha256_pkg::ctl_t   ctl,
	output logic [31:0]        w
);

	logic [31:0] mem [sha256_pkg::WORDS];
	logic [31:0] rda_q, rdb_q;
	logic [31:0] s0_q, s1_q, raw_q, w_q;
	logic [6:0]  t, tm1;
	logic        ph1, calc;
	logic [3:0]  addr_a, addr_b, waddr;
	logic [31:0] w_new, wdata;
	logic        wen;

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = sha256_pkg::rotr(x, 7) ^ sha256_pkg::rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = sha256_pkg::rotr(x, 17) ^ sha256_pkg::rotr(x, 19) ^ (x >> 10);
	endfunction

	assign t = ctl.cnt[7:1];
	assign tm1 = t - 7'd1;
	assign ph1 = ctl.cnt[0];
	assign calc = ctl.run && !ph1 && (t != 7'd0);

	always_comb begin
		if (ph1) begin
			addr_a = t[3:0] - 4'd7;
			addr_b = t[3:0];
		end else begin
			addr_a = (t[6:4] == 3'd0) ? t[3:0] : t[3:0] - 4'd2;
			addr_b = t[3:0] + 4'd1;
		end
	end

	assign w_new = (tm1[6:4] == 3'd0) ? raw_q : s1_q + s0_q + rda_q + rdb_q;

	assign wen = ctl.wr_en || calc;
	assign waddr = calc ? tm1[3:0] : ctl.wr_addr;
	assign wdata = calc ? w_new : ctl.wr_data;

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		rda_q <= mem[addr_a];
		rdb_q <= mem[addr_b];
	end

	always_ff @(posedge clk) begin
		if (ctl.run && ph1) begin
			s1_q <= ssig1(rda_q);
			s0_q <= ssig0(rdb_q);
			raw_q <= rda_q;
		end
		if (calc) begin
			w_q <= w_new;
		end
	end

	assign w = w_q;

endmodule

// ===== src/sha256_round.sv =====
// working variables, compression round and chaining hash
module sha256_round (
	input  logic               clk,
	input  logic               arst_n,
	input  sha256_pkg::ctl_t   ctl,
	input  logic [31:0]        w,
	input  logic [2:0]         sel,
	output logic [31:0]        digest
);

	logic [31:0] v_q [sha256_pkg::HASH_WORDS];
	logic [31:0] chain_q [sha256_pkg::HASH_WORDS];
	logic [6:0]  tm1;
	logic        step;
	logic [31:0] bs0, bs1, ch, maj, t1, t2;

	assign tm1 = ctl.cnt[7:1] - 7'd1;
	assign step = ctl.run && ctl.cnt[0] && (ctl.cnt[7:1] != 7'd0);

	always_comb begin
		bs1 = sha256_pkg::rotr(v_q[4], 6) ^ sha256_pkg::rotr(v_q[4], 11)
			^ sha256_pkg::rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + bs1 + ch + sha256_pkg::K_TABLE[tm1[5:0]] + w;
		bs0 = sha256_pkg::rotr(v_q[0], 2) ^ sha256_pkg::rotr(v_q[0], 13)
			^ sha256_pkg::rotr(v_q[0], 22);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = bs0 + maj;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < sha256_pkg::HASH_WORDS; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sha256_pkg::HASH_WORDS; i++) begin
				chain_q[i] <= sha256_pkg::IV_TABLE[i];
			end
		end else if (ctl.iv) begin
			for (int i = 0; i < sha256_pkg::HASH_WORDS; i++) begin
				chain_q[i] <= sha256_pkg::IV_TABLE[i];
			end
		end else if (ctl.add) begin
			for (int i = 0; i < sha256_pkg::HASH_WORDS; i++) begin
				chain_q[i] <= chain_q[i] + v_q[i];
			end
		end
	end

	assign digest = chain_q[sel];

endmodule
